/* design/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types, character codes and per-byte parse functions for the SMTP
// reply parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] POS_SEP  = 3'd3;
  localparam logic [2:0] POS_TEXT = 3'd4;

  // Pending result beats held between parser and output port.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_DIGITS   = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_SEP      = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0] line_pos;
    logic [9:0] digit_acc;
    logic [9:0] first_code;
    logic       have_code;
    logic       cr_held;
    logic       text_nonempty;
    status_t    line_status;
    logic       sep_is_space;
  } srp_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
    logic [9:0] reply_code;
    status_t    status;
  } srp_result_t;

  typedef struct packed {
    srp_state_t  st;
    logic        emit;
    srp_result_t res;
  } srp_step_t;

  function automatic logic text_ok(status_t s);
    return (s == ST_OK) || (s == ST_SEP);
  endfunction

  function automatic srp_step_t line_byte(srp_state_t s, logic [7:0] b);
    srp_step_t r;
    logic      is_digit;
    r.st     = s;
    r.emit   = 1'b0;
    r.res    = '0;
    is_digit = (b >= 8'h30) && (b <= 8'h39);
    if (s.line_pos < POS_SEP) begin
      if (is_digit) begin
        // acc * 10 + digit, kept mod 1024
        r.st.digit_acc = (s.digit_acc << 3) + (s.digit_acc << 1) + {6'd0, b[3:0]};
      end else if (s.line_status == ST_OK) begin
        r.st.line_status = ST_DIGITS;
      end
      r.st.line_pos = s.line_pos + 3'd1;
    end else if (s.line_pos == POS_SEP) begin
      if (s.line_status == ST_OK) begin
        if (s.have_code) begin
          if (s.digit_acc != s.first_code) r.st.line_status = ST_MISMATCH;
        end else begin
          r.st.first_code = s.digit_acc;
          r.st.have_code  = 1'b1;
        end
      end
      if (r.st.line_status == ST_OK) begin
        if (b == CH_SPACE) r.st.sep_is_space = 1'b1;
        else if (b != CH_DASH) r.st.line_status = ST_SEP;
      end
      if (text_ok(r.st.line_status) && s.text_nonempty) begin
        r.emit          = 1'b1;
        r.res.text_byte = CH_LF;
      end
      r.st.line_pos = POS_TEXT;
    end else begin
      if (text_ok(s.line_status)) begin
        r.emit             = 1'b1;
        r.res.text_byte    = b;
        r.st.text_nonempty = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic srp_step_t line_end(srp_state_t s);
    srp_step_t r;
    status_t   fin;
    fin = (s.line_pos < POS_TEXT) ? ST_SHORT : s.line_status;
    r.emit           = 1'b1;
    r.res.text_byte  = 8'd0;
    r.res.last       = 1'b1;
    r.res.reply_code = s.have_code ? s.first_code : 10'd0;
    r.res.status     = fin;
    r.st             = '0;
    if (fin == ST_OK && !s.sep_is_space) begin
      // continuation line: keep the reply context
      r.st.first_code    = s.first_code;
      r.st.have_code     = s.have_code;
      r.st.text_nonempty = s.text_nonempty;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/srp_step.sv */
// ----------------------------------------------------------------------------
// srp_step
// Next-state and result logic for one received byte, including a held CR
// that turns out not to start a line end. Yields up to two result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_step
  import srp_pkg::*;
(
  input  srp_state_t  cur,
  input  logic [7:0]  rx_byte,
  output srp_state_t  nxt,
  output logic [1:0]  n_res,
  output srp_result_t res0,
  output srp_result_t res1
);

  srp_state_t s0;
  srp_step_t  held;
  srp_step_t  body;
  srp_step_t  fin;
  logic       held_used;
  logic       is_end;

  always_comb begin
    held      = '0;
    body      = '0;
    fin       = '0;
    held_used = 1'b0;
    is_end    = 1'b0;
    s0        = cur;
    s0.cr_held = 1'b0;

    if (cur.cr_held && rx_byte == CH_LF) begin
      is_end = 1'b1;
      fin    = line_end(s0);
    end else begin
      if (cur.cr_held) begin
        // lone CR is a plain line byte, handled ahead of this one
        held      = line_byte(s0, CH_CR);
        held_used = held.emit;
        s0        = held.st;
      end
      if (rx_byte == CH_CR) begin
        body          = '0;
        body.st       = s0;
        body.st.cr_held = 1'b1;
      end else begin
        body = line_byte(s0, rx_byte);
      end
    end

    if (is_end) begin
      nxt   = fin.st;
      n_res = 2'd1;
      res0  = fin.res;
      res1  = '0;
    end else begin
      nxt   = body.st;
      n_res = {1'b0, held_used} + {1'b0, body.emit};
      res0  = held_used ? held.res : body.res;
      res1  = body.res;
    end
  end

endmodule

`default_nettype wire

/* design/srp_out_queue.sv */
// ----------------------------------------------------------------------------
// srp_out_queue
// Small result queue: takes zero, one or two beats per cycle, gives one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_out_queue
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  n_push,
  input  srp_result_t din0,
  input  srp_result_t din1,
  input  logic        pop,
  output logic        not_empty,
  output logic        room2,
  output srp_result_t dout
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  srp_result_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign not_empty = (count != '0);
  assign room2     = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wr_ptr] <= din0;
    if (n_push == 2'd2) mem[wr_ptr + PTR_W'(1)] <= din1;
  end

endmodule

`default_nettype wire

/* design/smtp_reply_parser_unit.sv */
// ----------------------------------------------------------------------------
// smtp_reply_parser_unit
// SMTP reply parser: byte stream in, reply text beats and end-of-reply
// code/status beats out.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. Its parse is finished in the cycle it
// is accepted and its result beats (none, one or two; two only when a held CR
// proves to be a plain byte) go into a four-entry result queue. The output
// side drains one beat per clock with out_stall low; the input is stalled
// while more than two beats are pending, so a byte stream that yields at most
// one beat per byte then runs at full rate. A beat with last high carries the
// reply code and status; after any error the parser starts a fresh reply.
`timescale 1ns / 1ps
`default_nettype none

module smtp_reply_parser_unit
  import srp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] text_byte,
  output logic       last,
  output logic [9:0] reply_code,
  output logic [2:0] status
);

  srp_state_t  state;
  srp_state_t  state_next;
  logic [1:0]  n_res;
  srp_result_t res0;
  srp_result_t res1;
  srp_result_t head;
  logic        room2;
  logic        accept;

  assign in_stall = !room2;
  assign accept   = in_valid && room2;

  srp_step u_step (
    .cur     (state),
    .rx_byte (rx_byte),
    .nxt     (state_next),
    .n_res   (n_res),
    .res0    (res0),
    .res1    (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  srp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .n_push    (accept ? n_res : 2'd0),
    .din0      (res0),
    .din1      (res1),
    .pop       (out_valid && !out_stall),
    .not_empty (out_valid),
    .room2     (room2),
    .dout      (head)
  );

  assign text_byte  = head.text_byte;
  assign last       = head.last;
  assign reply_code = head.reply_code;
  assign status     = head.status;

endmodule

`default_nettype wire
